@@ sv/swstat_pkg.sv @@
// Shared types and constants for the sliding window statistics block.
package swstat_pkg;

  localparam int CFG_W   = 9;
  localparam int MEAN_W  = 32;
  localparam int VAR_W   = 56;
  localparam int COUNT_W = 16;

  typedef struct packed {
    logic latch;
    logic rd_old;
    logic sq_old;
    logic upd;
    logic start;
    logic mean_take;
    logic var_start;
    logic var_zero;
    logic var_take;
    logic load_out;
  } swstat_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic mul_done;
    logic div_done;
    logic n_gt1;
    logic out_free;
  } swstat_sts_t;

endpackage

@@ sv/swstat_div.sv @@
// Restoring divider, one quotient bit per cycle.
module swstat_div #(
  parameter int N_W = 72,
  parameter int D_W = 18
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [N_W-1:0] dividend,
  input  logic [D_W-1:0] divisor,
  output logic           busy,
  output logic [N_W-1:0] quotient
);

  localparam int C_W = $clog2(N_W + 1);

  logic [D_W-1:0] rem;
  logic [D_W-1:0] dvs;
  logic [C_W-1:0] cnt;
  logic [D_W:0]   trial;
  logic           qbit;
  logic [D_W:0]   diff;

  assign trial = {rem, quotient[N_W-1]};
  assign qbit  = trial >= {1'b0, dvs};
  assign diff  = trial - {1'b0, dvs};
  assign busy  = cnt != '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= C_W'(N_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dvs      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= qbit ? diff[D_W-1:0] : trial[D_W-1:0];
      quotient <= {quotient[N_W-2:0], qbit};
    end
  end

endmodule

@@ sv/swstat_dp.sv @@
// Datapath: window memory, sums, extremes scan, multiplier and output register.
module swstat_dp import swstat_pkg::*; #(
  parameter int WINDOW_MAX  = 256,
  parameter int SAMPLE_BITS = 24,
  parameter int FRAC_BITS   = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  swstat_cmd_t                   cmd,
  output swstat_sts_t                   sts,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic                          window_size_we,
  input  logic [CFG_W-1:0]              window_size,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic signed [MEAN_W-1:0]      mean,
  output logic [VAR_W-1:0]              variance,
  output logic signed [SAMPLE_BITS-1:0] window_min,
  output logic signed [SAMPLE_BITS-1:0] window_max,
  output logic signed [SAMPLE_BITS-1:0] running_min,
  output logic signed [SAMPLE_BITS-1:0] running_max,
  output logic [COUNT_W-1:0]            samples_seen,
  output logic                          window_full
);

  localparam int AW       = $clog2(WINDOW_MAX);
  localparam int CNT_W    = $clog2(WINDOW_MAX + 1);
  localparam int SUM_W    = SAMPLE_BITS + CNT_W;
  localparam int MAG_W    = SUM_W - 1;
  localparam int SQE_W    = 2 * SAMPLE_BITS - 1;
  localparam int SQ_W     = 2 * SAMPLE_BITS + CNT_W - 2;
  localparam int A_W      = SQ_W + CNT_W;
  localparam int DIV_W    = A_W + FRAC_BITS;
  localparam int DEN_W    = 2 * CNT_W;
  localparam int QM_W     = DIV_W > MEAN_W ? DIV_W : MEAN_W;
  localparam int QX_W     = DIV_W > VAR_W ? DIV_W : VAR_W + 1;
  localparam int WS_RESET = WINDOW_MAX < 16 ? WINDOW_MAX : 16;

  logic signed [SAMPLE_BITS-1:0] mem [WINDOW_MAX];
  logic signed [SAMPLE_BITS-1:0] rd_data;
  logic [AW-1:0]                 rd_addr;

  logic [CNT_W-1:0]              wsize;
  logic [CNT_W-1:0]              ws_clamp;
  logic [AW-1:0]                 wp;
  logic [COUNT_W-1:0]            count;
  logic signed [SUM_W-1:0]       sum;
  logic [SQ_W-1:0]               sq;
  logic signed [SAMPLE_BITS-1:0] rmin;
  logic signed [SAMPLE_BITS-1:0] rmax;
  logic [CNT_W-1:0]              n;

  logic signed [SAMPLE_BITS-1:0] x;
  logic signed [SAMPLE_BITS-1:0] old_r;
  logic [SQE_W-1:0]              xsq;
  logic [SQE_W-1:0]              osq;
  logic signed [2*SAMPLE_BITS-1:0] xprod;
  logic signed [2*SAMPLE_BITS-1:0] oprod;

  logic                          was_full;
  logic [COUNT_W-1:0]            cnt_new;
  logic [CNT_W-1:0]              n_new;
  logic [CNT_W-1:0]              wp_inc;

  logic [CNT_W-1:0]              k;
  logic                          pv;
  logic                          first;
  logic signed [SAMPLE_BITS-1:0] wmin;
  logic signed [SAMPLE_BITS-1:0] wmax;

  logic [CNT_W-1:0]              mul_m;
  logic [A_W-1:0]                mul_add;
  logic [A_W-1:0]                mul_acc;
  logic [A_W-1:0]                bsq;
  logic [DEN_W-1:0]              den;
  logic [SUM_W-1:0]              sneg;
  logic [MAG_W-1:0]              mag;
  logic [A_W-1:0]                bprod;
  logic [DEN_W-1:0]              den_prod;
  logic [A_W-1:0]                dvar;

  logic                          div_start;
  logic [DIV_W-1:0]              div_num;
  logic [DEN_W-1:0]              div_den;
  logic                          div_busy;
  logic [DIV_W-1:0]              div_q;
  logic [QM_W-1:0]               qm;
  logic [QM_W-1:0]               qm_s;
  logic [QX_W-1:0]               qx;

  logic signed [MEAN_W-1:0]      mean_r;
  logic [VAR_W-1:0]              var_r;

  always_comb begin
    if (window_size == '0) begin
      ws_clamp = CNT_W'(1);
    end else if (32'(window_size) > WINDOW_MAX) begin
      ws_clamp = CNT_W'(WINDOW_MAX);
    end else begin
      ws_clamp = CNT_W'(window_size);
    end
  end

  assign xprod    = x * x;
  assign oprod    = rd_data * rd_data;
  assign was_full = 32'(count) >= 32'(wsize);
  assign cnt_new  = (count != '1) ? count + 1'b1 : count;
  assign n_new    = (32'(cnt_new) < 32'(wsize)) ? CNT_W'(cnt_new) : wsize;
  assign wp_inc   = CNT_W'(wp) + 1'b1;

  assign sneg     = -sum;
  assign mag      = sum[SUM_W-1] ? sneg[MAG_W-1:0] : sum[MAG_W-1:0];
  assign bprod    = mag * mag;
  assign den_prod = n * (n - 1'b1);
  assign dvar     = (mul_acc >= bsq) ? mul_acc - bsq : '0;

  assign rd_addr  = cmd.rd_old ? wp : k[AW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.upd) begin
      mem[wp] <= x;
    end
    rd_data <= mem[rd_addr];
  end

  // window state
  always_ff @(posedge clk) begin
    if (rst) begin
      wsize <= CNT_W'(WS_RESET);
      wp    <= '0;
      count <= '0;
      sum   <= '0;
      sq    <= '0;
      rmin  <= '0;
      rmax  <= '0;
      n     <= CNT_W'(1);
    end else if (window_size_we) begin
      wsize <= ws_clamp;
      wp    <= '0;
      count <= '0;
      sum   <= '0;
      sq    <= '0;
      rmin  <= '0;
      rmax  <= '0;
    end else if (cmd.upd) begin
      wp    <= (wp_inc == wsize) ? '0 : wp_inc[AW-1:0];
      count <= cnt_new;
      sum   <= sum + SUM_W'(x) - (was_full ? SUM_W'(old_r) : '0);
      sq    <= sq + SQ_W'(xsq) - (was_full ? SQ_W'(osq) : '0);
      n     <= n_new;
      if (n_new > CNT_W'(1)) begin
        if (x < rmin) rmin <= x;
        if (x > rmax) rmax <= x;
      end else begin
        rmin <= x;
        rmax <= x;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      x <= sample;
    end
    if (cmd.rd_old) begin
      xsq <= xprod[SQE_W-1:0];
    end
    if (cmd.sq_old) begin
      old_r <= rd_data;
      osq   <= oprod[SQE_W-1:0];
    end
    if (cmd.start) begin
      bsq <= bprod;
      den <= den_prod;
    end
  end

  // extremes scan, one entry per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      k  <= '0;
      pv <= 1'b0;
    end else if (cmd.start) begin
      k  <= '0;
      pv <= 1'b0;
    end else if (k < n) begin
      k  <= k + 1'b1;
      pv <= 1'b1;
    end else begin
      pv <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      first <= 1'b1;
    end else if (pv) begin
      first <= 1'b0;
      if (first || rd_data < wmin) wmin <= rd_data;
      if (first || rd_data > wmax) wmax <= rd_data;
    end
  end

  // n times sum of squares, shift and add
  always_ff @(posedge clk) begin
    if (rst) begin
      mul_m <= '0;
    end else if (cmd.start) begin
      mul_m <= n;
    end else if (mul_m != '0) begin
      mul_m <= mul_m >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      mul_acc <= '0;
      mul_add <= A_W'(sq);
    end else if (mul_m != '0) begin
      if (mul_m[0]) mul_acc <= mul_acc + mul_add;
      mul_add <= mul_add << 1;
    end
  end

  assign div_start = cmd.start | cmd.var_start;
  assign div_num   = cmd.var_start ? (DIV_W'(dvar) << FRAC_BITS)
                                   : (DIV_W'(mag) << FRAC_BITS);
  assign div_den   = cmd.var_start ? den : DEN_W'(n);

  swstat_div #(
    .N_W (DIV_W),
    .D_W (DEN_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (div_den),
    .busy     (div_busy),
    .quotient (div_q)
  );

  assign qm   = QM_W'(div_q);
  assign qm_s = sum[SUM_W-1] ? -qm : qm;
  assign qx   = QX_W'(div_q);

  always_ff @(posedge clk) begin
    if (cmd.mean_take) begin
      mean_r <= qm_s[MEAN_W-1:0];
    end
    if (cmd.var_zero) begin
      var_r <= '0;
    end else if (cmd.var_take) begin
      var_r <= (qx[QX_W-1:VAR_W] != '0) ? '1 : qx[VAR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      mean         <= mean_r;
      variance     <= var_r;
      window_min   <= wmin;
      window_max   <= wmax;
      running_min  <= rmin;
      running_max  <= rmax;
      samples_seen <= count;
      window_full  <= was_full;
    end
  end

  assign sts.scan_done = (k == n) && !pv;
  assign sts.mul_done  = mul_m == '0;
  assign sts.div_done  = !div_busy;
  assign sts.n_gt1     = n > CNT_W'(1);
  assign sts.out_free  = !out_valid || out_ready;

endmodule

@@ sv/swstat_ctrl.sv @@
// Controller: sequences one sample through the datapath.
module swstat_ctrl import swstat_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  swstat_sts_t sts,
  output swstat_cmd_t cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RDOLD = 3'd1;
  localparam logic [2:0] S_SQ    = 3'd2;
  localparam logic [2:0] S_UPD   = 3'd3;
  localparam logic [2:0] S_STRT  = 3'd4;
  localparam logic [2:0] S_WAIT  = 3'd5;
  localparam logic [2:0] S_VWAIT = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_ready = state == S_IDLE;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = S_RDOLD;
        end
      end
      S_RDOLD: begin
        cmd.rd_old = 1'b1;
        state_next = S_SQ;
      end
      S_SQ: begin
        cmd.sq_old = 1'b1;
        state_next = S_UPD;
      end
      S_UPD: begin
        cmd.upd    = 1'b1;
        state_next = S_STRT;
      end
      S_STRT: begin
        cmd.start  = 1'b1;
        state_next = S_WAIT;
      end
      S_WAIT: begin
        if (sts.scan_done && sts.mul_done && sts.div_done) begin
          cmd.mean_take = 1'b1;
          if (sts.n_gt1) begin
            cmd.var_start = 1'b1;
            state_next    = S_VWAIT;
          end else begin
            cmd.var_zero = 1'b1;
            state_next   = S_DONE;
          end
        end
      end
      S_VWAIT: begin
        if (sts.div_done) begin
          cmd.var_take = 1'b1;
          state_next   = S_DONE;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ sv/sliding_window_statistics.sv @@
// Sliding window statistics: mean, variance, window and running extremes.
// Input channel: in_valid/in_ready carry one signed sample per beat.
// Output channel: out_valid/out_ready carry one result beat per sample:
// mean, variance, window and running min/max, samples_seen, window_full.
// window_size_we writes the window length (0 reads as 1, above WINDOW_MAX
// reads as WINDOW_MAX) and empties the window; write only while idle.
// Each sample runs latch, old-entry read, old-entry square, update, start,
// then waits for the scan, the multiplier and the mean division (divider
// 72 bits wide with defaults) and, with more than one sample, the variance
// division; the next sample is taken in the cycle after the result loads.
// One sample is processed at a time; the min/max scan reads one window
// entry per cycle from the window memory, and the shared bit-serial
// divider produces the mean and, with more than one sample, the variance.
// The result sits in an output register; a stalled receiver holds the
// beat while the next sample is already processed, stalling only when
// that next result is ready to load.
// Reset: window length 16 (WINDOW_MAX if smaller), window empty, no result
// pending. Window memory is not cleared; only written entries are used.
module sliding_window_statistics import swstat_pkg::*; #(
  parameter int WINDOW_MAX  = 256,
  parameter int SAMPLE_BITS = 24,
  parameter int FRAC_BITS   = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic                          window_size_we,
  input  logic [CFG_W-1:0]              window_size,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [MEAN_W-1:0]      mean,
  output logic [VAR_W-1:0]              variance,
  output logic signed [SAMPLE_BITS-1:0] window_min,
  output logic signed [SAMPLE_BITS-1:0] window_max,
  output logic signed [SAMPLE_BITS-1:0] running_min,
  output logic signed [SAMPLE_BITS-1:0] running_max,
  output logic [COUNT_W-1:0]            samples_seen,
  output logic                          window_full
);

  swstat_cmd_t cmd;
  swstat_sts_t sts;

  swstat_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  swstat_dp #(
    .WINDOW_MAX  (WINDOW_MAX),
    .SAMPLE_BITS (SAMPLE_BITS),
    .FRAC_BITS   (FRAC_BITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .sample         (sample),
    .window_size_we (window_size_we),
    .window_size    (window_size),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .mean           (mean),
    .variance       (variance),
    .window_min     (window_min),
    .window_max     (window_max),
    .running_min    (running_min),
    .running_max    (running_max),
    .samples_seen   (samples_seen),
    .window_full    (window_full)
  );

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("sample accepted while another is in flight");

  a_window_order: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> window_min <= window_max)
    else $error("window min above window max");

  a_running_order: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> running_min <= running_max)
    else $error("running min above running max");

  a_load_once: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> in_ready)
    else $error("result loaded without returning to idle");

endmodule
